// ----- rtl/core/dxt_pkg.sv -----
`default_nettype none

package dxt_pkg;

    // Block mode register codes. Code 3 is unused and decodes as DXT1.
    localparam logic [1:0] MODE_DXT1 = 2'd0;
    localparam logic [1:0] MODE_DXT3 = 2'd1;
    localparam logic [1:0] MODE_DXT5 = 2'd2;

    // Pixels per 4x4 block and the index of the last one.
    localparam int unsigned PIXELS = 16;
    localparam logic [3:0] LAST_PIXEL_INDEX = 4'(PIXELS - 1);

    // Division by 3 of a color sum below 768: multiply by 683, shift by 11.
    localparam int unsigned DIV3_SHIFT = 11;
    localparam logic [9:0] RECIP3 = 10'd683;

    // Division by 7 or 5 of an alpha sum below 2048: multiply, shift by 15.
    localparam int unsigned ADIV_SHIFT = 15;
    localparam logic [12:0] RECIP7 = 13'd4682;
    localparam logic [12:0] RECIP5 = 13'd6554;

    // How the alpha value of a pixel is finished in the last stage.
    localparam logic [1:0] ASEL_DIRECT = 2'd0;
    localparam logic [1:0] ASEL_DIV7 = 2'd1;
    localparam logic [1:0] ASEL_DIV5 = 2'd2;

    // One 8-bit value per color channel: red, green, blue.
    typedef logic [2:0][7:0] rgb_t;

endpackage

`default_nettype wire

// ----- rtl/core/dxt_block_decoder.sv -----
// DXT1 / DXT3 / DXT5 texture block decoder.
//
// Input channel: one compressed 4x4 block per transaction (color_block and
// alpha_block), handshaked with block_valid and block_stall. Output channel:
// one RGBA pixel per transaction with its pixel_index (row-major) and a
// last_pixel mark on the sixteenth pixel, handshaked with pixel_valid and
// pixel_stall. The block mode is written through cfg_wr_en / cfg_wr_data
// while the decoder is idle, a rule on the user; the block does not enforce it.
//
// A block sits in a holding register while its pixels are issued one per
// cycle, unless the receiver stalls, into a four-stage pixel pipeline (field
// extract, sum, reciprocal multiply, output register). A pixel passes from
// the holding register through the stage 1, 2 and 3 registers to the output
// register. The next block is taken on the cycle that its predecessor's last
// pixel is issued, so blocks stream without gaps.
//
// Reset clears all valid bits and sets the mode to DXT1. When the receiver
// stalls a valid pixel, the whole pipeline holds; block_stall is high while a
// block is held and not issuing its last pixel. Nothing is dropped or repeated.
`default_nettype none

module dxt_block_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        block_valid,
    output logic             block_stall,
    input  wire logic [63:0] color_block,
    input  wire logic [63:0] alpha_block,
    output logic             pixel_valid,
    input  wire logic        pixel_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic [3:0]       pixel_index,
    output logic             last_pixel
);
    import dxt_pkg::*;

    // Mode register.
    logic [1:0] mode_reg;

    // Block holding register.
    logic        blk_valid_reg;
    logic [63:0] color_reg;
    logic [63:0] alpha_reg;
    logic [3:0]  cnt_reg;

    // Stage 1: fields of one pixel.
    logic       s1_valid_reg;
    logic [3:0] s1_pix_reg;
    logic [1:0] s1_idx_reg;
    logic       s1_four_reg;
    logic       s1_punch_reg;
    logic [1:0] s1_mode_reg;
    rgb_t       s1_e0_reg;
    rgb_t       s1_e1_reg;
    logic [7:0] s1_a0_reg;
    logic [7:0] s1_a1_reg;
    logic [2:0] s1_code_reg;
    logic [3:0] s1_nib_reg;

    // Stage 2: sums to divide, or final values.
    logic            s2_valid_reg;
    logic [3:0]      s2_pix_reg;
    logic [2:0][9:0] s2_num_reg;
    logic [2:0]      s2_div_reg;
    logic [10:0]     s2_anum_reg;
    logic [1:0]      s2_asel_reg;

    // Stage 3: reciprocal products.
    logic             s3_valid_reg;
    logic [3:0]       s3_pix_reg;
    logic [2:0][19:0] s3_prod_reg;
    logic [2:0]       s3_div_reg;
    logic [23:0]      s3_aprod_reg;
    logic [1:0]       s3_asel_reg;

    // Stage 4: output register.
    logic       out_valid_reg;
    rgb_t       out_rgb_reg;
    logic [7:0] out_alpha_reg;
    logic [3:0] out_pix_reg;

    logic adv;
    logic take;
    logic issue;

    // Next values.
    logic [3:0]       s1_pix_next;
    logic [1:0]       s1_idx_next;
    logic             s1_four_next;
    logic             s1_punch_next;
    rgb_t             s1_e0_next;
    rgb_t             s1_e1_next;
    logic [2:0]       s1_code_next;
    logic [3:0]       s1_nib_next;
    logic [2:0][9:0]  s2_num_next;
    logic [2:0]       s2_div_next;
    logic [10:0]      s2_anum_next;
    logic [1:0]       s2_asel_next;
    logic [2:0][19:0] s3_prod_next;
    logic [23:0]      s3_aprod_next;
    rgb_t             out_rgb_next;
    logic [7:0]       out_alpha_next;

    // Pipeline control: every stage moves when the output can move.
    assign adv         = !out_valid_reg || !pixel_stall;
    assign issue       = blk_valid_reg && adv;
    assign block_stall = blk_valid_reg && !(adv && (cnt_reg == LAST_PIXEL_INDEX));
    assign take        = block_valid && !block_stall;

    // Stage 1 extraction from the held block.
    always_comb
    begin
        logic [15:0] c0;
        logic [15:0] c1;
        logic [31:0] idx_row;
        logic [47:0] code_row;
        logic [5:0]  code_off;
        c0       = color_reg[15:0];
        c1       = color_reg[31:16];
        idx_row  = color_reg[63:32];
        code_row = alpha_reg[63:16];
        code_off = {1'b0, cnt_reg, 1'b0} + {2'b00, cnt_reg};

        s1_pix_next   = cnt_reg;
        s1_idx_next   = idx_row[{cnt_reg, 1'b0} +: 2];
        s1_four_next  = (c0 > c1) || (mode_reg == MODE_DXT5);
        s1_punch_next = (c0 <= c1);
        s1_e0_next    = {{c0[15:11], 3'b000}, {c0[10:5], 2'b00}, {c0[4:0], 3'b000}};
        s1_e1_next    = {{c1[15:11], 3'b000}, {c1[10:5], 2'b00}, {c1[4:0], 3'b000}};
        s1_code_next  = code_row[code_off +: 3];
        s1_nib_next   = alpha_reg[{cnt_reg, 2'b00} +: 4];
    end

    // Stage 2: palette sums per channel.
    always_comb
    begin
        logic [8:0] half;
        for (int ch = 0; ch < 3; ch++)
        begin
            half = ({1'b0, s1_e0_reg[ch]} + {1'b0, s1_e1_reg[ch]} + 9'd1);
            s2_num_next[ch] = '0;
            s2_div_next[ch] = 1'b0;
            case (s1_idx_reg)
                2'd0: s2_num_next[ch] = {2'b00, s1_e0_reg[ch]};
                2'd1: s2_num_next[ch] = {2'b00, s1_e1_reg[ch]};
                2'd2:
                begin
                    if (s1_four_reg)
                    begin
                        s2_num_next[ch] = {1'b0, s1_e0_reg[ch], 1'b0}
                                        + {2'b00, s1_e1_reg[ch]} + 10'd1;
                        s2_div_next[ch] = 1'b1;
                    end
                    else
                    begin
                        s2_num_next[ch] = {2'b00, half[8:1]};
                    end
                end
                default:
                begin
                    if (s1_four_reg)
                    begin
                        s2_num_next[ch] = {1'b0, s1_e1_reg[ch], 1'b0}
                                        + {2'b00, s1_e0_reg[ch]} + 10'd1;
                        s2_div_next[ch] = 1'b1;
                    end
                    else
                    begin
                        s2_num_next[ch] = 10'd255;
                    end
                end
            endcase
        end
    end

    // Stage 2: alpha sum or final alpha.
    always_comb
    begin
        logic [2:0] w0;
        logic [2:0] w1;
        logic [3:0] w0_wide;
        logic [10:0] p0;
        logic [10:0] p1;
        w1      = s1_code_reg - 3'd1;
        if (s1_a0_reg > s1_a1_reg)
            w0_wide = 4'd8 - {1'b0, s1_code_reg};
        else
            w0_wide = 4'd6 - {1'b0, s1_code_reg};
        w0      = w0_wide[2:0];
        p0      = {8'b0, w0} * {3'b0, s1_a0_reg};
        p1      = {8'b0, w1} * {3'b0, s1_a1_reg};

        s2_anum_next = '0;
        s2_asel_next = ASEL_DIRECT;
        case (s1_mode_reg)
            MODE_DXT3: s2_anum_next = {3'b000, s1_nib_reg, s1_nib_reg};
            MODE_DXT5:
            begin
                if (s1_code_reg == 3'd0)
                    s2_anum_next = {3'b000, s1_a0_reg};
                else if (s1_code_reg == 3'd1)
                    s2_anum_next = {3'b000, s1_a1_reg};
                else if (s1_a0_reg > s1_a1_reg)
                begin
                    s2_anum_next = p0 + p1;
                    s2_asel_next = ASEL_DIV7;
                end
                else if (s1_code_reg == 3'd6)
                    s2_anum_next = 11'd0;
                else if (s1_code_reg == 3'd7)
                    s2_anum_next = 11'd255;
                else
                begin
                    s2_anum_next = p0 + p1;
                    s2_asel_next = ASEL_DIV5;
                end
            end
            default:
            begin
                if (s1_punch_reg && (s1_idx_reg == 2'd3))
                    s2_anum_next = 11'd0;
                else
                    s2_anum_next = 11'd255;
            end
        endcase
    end

    // Stage 3: reciprocal multiplies.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (s2_div_reg[ch])
                s3_prod_next[ch] = {10'b0, s2_num_reg[ch]} * {10'b0, RECIP3};
            else
                s3_prod_next[ch] = {10'b0, s2_num_reg[ch]};
        end
        case (s2_asel_reg)
            ASEL_DIV7: s3_aprod_next = {13'b0, s2_anum_reg} * {11'b0, RECIP7};
            ASEL_DIV5: s3_aprod_next = {13'b0, s2_anum_reg} * {11'b0, RECIP5};
            default:   s3_aprod_next = {13'b0, s2_anum_reg};
        endcase
    end

    // Stage 4: take the quotient bits or the direct value.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (s3_div_reg[ch])
                out_rgb_next[ch] = s3_prod_reg[ch][DIV3_SHIFT +: 8];
            else
                out_rgb_next[ch] = s3_prod_reg[ch][7:0];
        end
        if (s3_asel_reg == ASEL_DIRECT)
            out_alpha_next = s3_aprod_reg[7:0];
        else
            out_alpha_next = s3_aprod_reg[ADIV_SHIFT +: 8];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DXT1;
            blk_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (take)
            begin
                blk_valid_reg <= 1'b1;
                cnt_reg       <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == LAST_PIXEL_INDEX)
                    blk_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                s1_valid_reg  <= blk_valid_reg;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            color_reg <= color_block;
            alpha_reg <= alpha_block;
        end
        if (adv)
        begin
            s1_pix_reg    <= s1_pix_next;
            s1_idx_reg    <= s1_idx_next;
            s1_four_reg   <= s1_four_next;
            s1_punch_reg  <= s1_punch_next;
            s1_mode_reg   <= mode_reg;
            s1_e0_reg     <= s1_e0_next;
            s1_e1_reg     <= s1_e1_next;
            s1_a0_reg     <= alpha_reg[7:0];
            s1_a1_reg     <= alpha_reg[15:8];
            s1_code_reg   <= s1_code_next;
            s1_nib_reg    <= s1_nib_next;

            s2_pix_reg    <= s1_pix_reg;
            s2_num_reg    <= s2_num_next;
            s2_div_reg    <= s2_div_next;
            s2_anum_reg   <= s2_anum_next;
            s2_asel_reg   <= s2_asel_next;

            s3_pix_reg    <= s2_pix_reg;
            s3_prod_reg   <= s3_prod_next;
            s3_div_reg    <= s2_div_reg;
            s3_aprod_reg  <= s3_aprod_next;
            s3_asel_reg   <= s2_asel_reg;

            out_pix_reg   <= s3_pix_reg;
            out_rgb_reg   <= out_rgb_next;
            out_alpha_reg <= out_alpha_next;
        end
    end

    // Output port.
    assign pixel_valid = out_valid_reg;
    assign red         = out_rgb_reg[2];
    assign green       = out_rgb_reg[1];
    assign blue        = out_rgb_reg[0];
    assign alpha       = out_alpha_reg;
    assign pixel_index = out_pix_reg;
    assign last_pixel  = (out_pix_reg == LAST_PIXEL_INDEX);

endmodule

`default_nettype wire

// ----- rtl/core/dxt_checker.sv -----
`default_nettype none

module dxt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pixel_valid,
    input wire logic       pixel_stall,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic [7:0] alpha,
    input wire logic [3:0] pixel_index,
    input wire logic       last_pixel
);
    import dxt_pkg::*;

    // Index the next delivered pixel must carry.
    logic [3:0] exp_pix_reg;
    logic [3:0] exp_pix_next;

    assign exp_pix_next = pixel_index + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_pix_reg <= '0;
        else if (pixel_valid && !pixel_stall)
            exp_pix_reg <= exp_pix_next;
    end

    // Pixels of every block come out in row-major order from the first.
    a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (pixel_index == exp_pix_reg))
        else $error("pixel delivered out of order");

    // The last mark sits exactly on the final pixel of a block.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (last_pixel == (pixel_index == LAST_PIXEL_INDEX)))
        else $error("last pixel mark misplaced");

    // A stalled pixel transaction stays and holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(red)
            && $stable(green) && $stable(blue) && $stable(alpha)
            && $stable(pixel_index))
        else $error("stalled pixel changed");

endmodule

bind dxt_block_decoder dxt_checker u_dxt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .pixel_index (pixel_index),
    .last_pixel  (last_pixel)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    import dxt_pkg::*;

    // The fourth mode code has no name in the package and decodes as DXT1.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Settle time after the last pixel; the pixel pipeline is four stages deep.
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 120;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [63:0] cword;
        logic [63:0] aword;
    } block_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] pos;
        logic       last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        block_valid = 1'b0;
    logic        block_stall;
    logic [63:0] color_block = 64'd0;
    logic [63:0] alpha_block = 64'd0;
    logic        pixel_valid;
    logic        pixel_stall = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [3:0]  pixel_index;
    logic        last_pixel;

    // Blocks waiting to be offered and pixels waiting to be seen.
    block_t block_q[$];
    pixel_t pixel_q[$];

    logic [1:0] mode_model = MODE_DXT1;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_at = -1;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int blocks_in = 0;
    int pixels_out = 0;
    int err_count = 0;

    dxt_block_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .block_valid (block_valid),
        .block_stall (block_stall),
        .color_block (color_block),
        .alpha_block (alpha_block),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel)
    );

    always #2 clk = ~clk;

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Interpolated DXT5 alpha of one pixel.
    function automatic logic [7:0] dxt5_level(input logic [63:0] ab, input int p);
        int unsigned a0;
        int unsigned a1;
        int unsigned code;
        a0 = ab[7:0];
        a1 = ab[15:8];
        code = ab[16 + 3 * p +: 3];
        if (code == 0)
            return 8'(a0);
        if (code == 1)
            return 8'(a1);
        if (a0 > a1)
            return 8'(((8 - code) * a0 + (code - 1) * a1) / 7);
        if (code == 6)
            return 8'd0;
        if (code == 7)
            return 8'd255;
        return 8'(((6 - code) * a0 + (code - 1) * a1) / 5);
    endfunction

    // Expand one block into the sixteen pixels it should produce.
    task automatic decode_block(input logic [63:0] cb, input logic [63:0] ab);
        logic [15:0] e0;
        logic [15:0] e1;
        int unsigned pal [4][3];
        logic [1:0] sel;
        bit four;
        pixel_t px;
        e0 = cb[15:0];
        e1 = cb[31:16];
        four = (e0 > e1) || (mode_model == MODE_DXT5);
        pal[0][0] = {e0[15:11], 3'b000};
        pal[0][1] = {e0[10:5], 2'b00};
        pal[0][2] = {e0[4:0], 3'b000};
        pal[1][0] = {e1[15:11], 3'b000};
        pal[1][1] = {e1[10:5], 2'b00};
        pal[1][2] = {e1[4:0], 3'b000};
        for (int ch = 0; ch < 3; ch++) begin
            if (four) begin
                pal[2][ch] = (2 * pal[0][ch] + pal[1][ch] + 1) / 3;
                pal[3][ch] = (2 * pal[1][ch] + pal[0][ch] + 1) / 3;
            end else begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch] + 1) >> 1;
                pal[3][ch] = 255;
            end
        end
        for (int p = 0; p < PIXELS; p++) begin
            sel = cb[32 + 2 * p +: 2];
            px.red = 8'(pal[sel][0]);
            px.green = 8'(pal[sel][1]);
            px.blue = 8'(pal[sel][2]);
            case (mode_model)
                MODE_DXT3: px.alpha = 8'(ab[4 * p +: 4] * 17);
                MODE_DXT5: px.alpha = dxt5_level(ab, p);
                default:   px.alpha = (e0 <= e1 && sel == 2'd3) ? 8'd0 : 8'd255;
            endcase
            px.pos = 4'(p);
            px.last = (p == PIXELS - 1);
            pixel_q.push_back(px);
        end
    endtask

    // Block driver: predict on each accepted transaction, then offer the next block.
    always @(posedge clk) begin
        block_t nxt;
        if (block_valid && !block_stall) begin
            decode_block(color_block, alpha_block);
            blocks_in <= blocks_in + 1;
        end
        if (!block_valid || !block_stall) begin
            if (rst_n && block_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = block_q.pop_front();
                block_valid <= 1'b1;
                color_block <= nxt.cword;
                alpha_block <= nxt.aword;
            end else begin
                block_valid <= 1'b0;
            end
        end
    end

    // Pixel monitor: check each accepted transaction and choose the next stall.
    always @(posedge clk) begin
        pixel_t want;
        if (pixel_valid && !pixel_stall) begin
            pixels_out <= pixels_out + 1;
            if (pixel_q.size() == 0) begin
                flag_mismatch($sformatf("pixel %0d arrived with none expected", pixel_index));
            end else begin
                want = pixel_q.pop_front();
                if (red !== want.red)
                    flag_mismatch($sformatf("red of pixel %0d: got %0d, want %0d",
                                            want.pos, red, want.red));
                if (green !== want.green)
                    flag_mismatch($sformatf("green of pixel %0d: got %0d, want %0d",
                                            want.pos, green, want.green));
                if (blue !== want.blue)
                    flag_mismatch($sformatf("blue of pixel %0d: got %0d, want %0d",
                                            want.pos, blue, want.blue));
                if (alpha !== want.alpha)
                    flag_mismatch($sformatf("alpha of pixel %0d: got %0d, want %0d",
                                            want.pos, alpha, want.alpha));
                if (pixel_index !== want.pos)
                    flag_mismatch($sformatf("pixel_index: got %0d, want %0d",
                                            pixel_index, want.pos));
                if (last_pixel !== want.last)
                    flag_mismatch($sformatf("last_pixel of pixel %0d: got %b, want %b",
                                            want.pos, last_pixel, want.last));
            end
        end
        // One long hold-off lets the decoder fill up and push back on its input.
        if (hold_left > 0) begin
            pixel_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && hold_at >= 0 && blocks_in >= hold_at) begin
            pixel_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            pixel_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Write the mode register; only called while the decoder is idle.
    task automatic write_mode(input logic [1:0] m);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_model = m;
        @(negedge clk);
    endtask

    task automatic push_block(input logic [63:0] cw, input logic [63:0] aw);
        block_t b;
        b.cword = cw;
        b.aword = aw;
        block_q.push_back(b);
    endtask

    // DXT5 alpha word with the codes running up from a start value.
    function automatic logic [63:0] dxt5_word(input logic [7:0] a0, input logic [7:0] a1,
                                              input int first);
        logic [63:0] w;
        w = {48'd0, a1, a0};
        for (int p = 0; p < PIXELS; p++)
            w[16 + 3 * p +: 3] = 3'(first + p);
        return w;
    endfunction

    // Random block, leaning toward equal and extreme endpoints now and then.
    function automatic block_t random_block();
        block_t b;
        logic [15:0] e0;
        logic [15:0] e1;
        e0 = 16'($urandom);
        e1 = 16'($urandom);
        case ($urandom_range(7))
            0: e1 = e0;
            1: e0 = 16'h0000;
            2: e0 = 16'hffff;
            3: e1 = 16'hffff;
            default: ;
        endcase
        b.cword = {$urandom, $urandom};
        b.cword[31:0] = {e1, e0};
        b.aword = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            b.aword[15:8] = b.aword[7:0];
        return b;
    endfunction

    // Wait until no block is pending and no pixel is owed, then let things settle.
    task automatic wait_idle(input int limit);
        for (int n = 0; n < limit; n++) begin
            if (block_q.size() == 0 && !block_valid && pixel_q.size() == 0)
                break;
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input logic [1:0] m, input int send_pct, input int recv_pct,
                                input int count);
        write_mode(m);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
            block_q.push_back(random_block());
        wait_idle(1000000);
    endtask

    // Main sequence: directed blocks per mode, then random phases.
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 18;
        recv_idle_pct = 60;

        // DXT1: zero and all-ones blocks, both palette sizes, transparent index.
        write_mode(MODE_DXT1);
        push_block(64'd0, 64'd0);
        push_block('1, '1);
        push_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
        push_block({32'h1B1B1B1B, 16'hF81F, 16'h07E0}, {$urandom, $urandom});
        push_block({32'hFFFFFFFF, 16'h1234, 16'h1234}, 64'd0);
        wait_idle(1000000);

        // DXT3: every nibble value, ascending and descending across the positions.
        write_mode(MODE_DXT3);
        push_block({32'hE4E4E4E4, 16'h001F, 16'hF800}, 64'hFEDCBA9876543210);
        push_block({32'h1B1B1B1B, 16'hFFFF, 16'h0000}, 64'h0123456789ABCDEF);
        push_block(64'hAAAA5555_7BEF_8410, 64'd0);
        wait_idle(1000000);

        // DXT5: four colors even with endpoint0 below endpoint1; both alpha ramps.
        write_mode(MODE_DXT5);
        push_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, dxt5_word(8'hFF, 8'h00, 0));
        push_block({32'h1B1B1B1B, 16'h07E0, 16'hF81F}, dxt5_word(8'h10, 8'hF0, 0));
        push_block({32'h1B1B1B1B, 16'h07E0, 16'hF81F}, dxt5_word(8'h80, 8'h80, 3));
        push_block({32'hE4E4E4E4, 16'h8000, 16'h7FFF}, dxt5_word(8'hF0, 8'h10, 5));
        push_block('1, '1);
        push_block(64'd0, 64'd0);
        wait_idle(1000000);

        // The spare mode code should behave like DXT1.
        write_mode(MODE_SPARE);
        push_block({32'hE4E4E4E4, 16'h8000, 16'h7FFF}, '1);
        push_block({32'hE4E4E4E4, 16'h7FFF, 16'h8000}, '1);
        wait_idle(1000000);

        random_phase(MODE_DXT5, 18, 60, 40);
        random_phase(MODE_DXT3, 60, 18, 35);
        hold_at = blocks_in + 3;
        random_phase(MODE_DXT1, 0, 0, 40);
        random_phase(MODE_SPARE, 0, 0, 15);
        random_phase(MODE_DXT5, 0, 0, 20);

        wait_idle(20000);
        if (pixel_q.size() != 0)
            flag_mismatch($sformatf("%0d expected pixels never arrived", pixel_q.size()));

        $display("Run covered %0d blocks and %0d pixels in all four mode codes,",
                 blocks_in, pixels_out);
        $display("with random stalls on both ports and one long hold-off on the pixel side.");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Watchdog expired with %0d pixels outstanding.", pixel_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
